>>> rtl/qcpm_pkg.sv
// Shared types, widths and constants of the quadrotor cascade PID and motor mixer.
package qcpm_pkg;

	// Field widths.
	localparam int GAIN_W     = 12;
	localparam int ANG_W      = 16;
	localparam int RATE_W     = 12;
	localparam int THR_W      = 13;
	localparam int STICK_W    = 8;
	localparam int MOTOR_W    = 13;
	localparam int CFG_ADDR_W = 3;

	// Stream packing.
	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 56;

	// Internal arithmetic widths.
	localparam int ERR_W   = 20;  // rate errors in 1/128 deg/s
	localparam int HERR_W  = 18;  // heading error in 1/128 deg
	localparam int DIFF_W  = 21;  // rate error differences
	localparam int HDIFF_W = 19;  // heading error difference
	localparam int OPND_W  = 21;  // shared multiplier data operand
	localparam int PROD_W  = GAIN_W + 1 + OPND_W;
	localparam int ACC_W   = 36;
	localparam int FRAC_W  = 11;  // terms accumulate in units of 1/2048
	localparam int QUOT_W  = ACC_W - FRAC_W;
	localparam int TERM_W  = 16;
	localparam int INTEG_W = 16;
	localparam int ISUM_W  = INTEG_W + 1;
	localparam int MIX_W   = 18;
	localparam int STICK_SHIFT = 7;  // one stick step is 128 units
	localparam int RATE_SHIFT  = 7;  // whole deg/s to 1/128 deg/s

	localparam logic signed [ERR_W-1:0]  STICK_MID   = 20'sd15;
	localparam logic signed [ERR_W-1:0]  SEP_LIMIT   = 20'sd19200;
	localparam logic signed [ERR_W-1:0]  SEP_NEG     = -20'sd19200;
	localparam logic signed [ISUM_W-1:0] INT_LIMIT   = 17'sd32000;
	localparam logic signed [ISUM_W-1:0] INT_NEG     = -17'sd32000;
	localparam logic signed [TERM_W-1:0] TERM_MAX    = 16'sd32767;
	localparam logic signed [TERM_W-1:0] TERM_MIN    = -16'sd32767;
	localparam logic signed [MIX_W-1:0]  PWM_MAX_S   = 18'sd7150;
	localparam logic signed [MIX_W-1:0]  PWM_MIN_S   = 18'sd5;
	localparam logic [MOTOR_W-1:0]       MOTOR_MAX   = 13'd7150;
	localparam logic [MOTOR_W-1:0]       MOTOR_FLOOR = 13'd1;
	localparam logic [THR_W-1:0]         IDLE_THROTTLE = 13'd100;
	localparam logic [THR_W-1:0]         THR_DISARMED  = 13'd1;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KP_X  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KI_X  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KD_X  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KP_Y  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KI_Y  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE_KD_Y  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_HEADING_KP = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_HEADING_KD = 3'd7;

	// Accumulator control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic acc_load;
		logic acc_add;
	} mac_ctrl_t;

endpackage

>>> rtl/qcpm_mac.sv
// Shared multiply-accumulate unit with divide-by-2048 and term saturation.
module qcpm_mac (
	input  logic                                      clk,
	input  qcpm_pkg::mac_ctrl_t                       ctrl,
	input  logic [qcpm_pkg::GAIN_W-1:0]               gain,
	input  logic signed [qcpm_pkg::OPND_W-1:0]        opnd,
	output logic signed [qcpm_pkg::TERM_W-1:0]        term
);

	logic signed [qcpm_pkg::GAIN_W:0]       gain_s;
	logic signed [qcpm_pkg::PROD_W-1:0]     prod_q;
	logic signed [qcpm_pkg::ACC_W-1:0]      prod_ext;
	logic signed [qcpm_pkg::ACC_W-1:0]      acc_q;
	logic signed [qcpm_pkg::ACC_W-1:0]      acc_bias;
	logic signed [qcpm_pkg::QUOT_W-1:0]     quot;

	assign gain_s = signed'({1'b0, gain});

	// Product is registered before it reaches the accumulator.
	always_ff @(posedge clk) begin
		prod_q <= qcpm_pkg::PROD_W'(gain_s) * qcpm_pkg::PROD_W'(opnd);
	end

	assign prod_ext = qcpm_pkg::ACC_W'(prod_q);

	always_ff @(posedge clk) begin
		if (ctrl.acc_load) begin
			acc_q <= prod_ext;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// Division truncates toward zero: negative sums are biased before the shift.
	assign acc_bias = acc_q[qcpm_pkg::ACC_W-1]
		? acc_q + qcpm_pkg::ACC_W'((1 << qcpm_pkg::FRAC_W) - 1)
		: acc_q;
	assign quot = acc_bias[qcpm_pkg::ACC_W-1:qcpm_pkg::FRAC_W];

	always_comb begin
		if (quot > qcpm_pkg::TERM_MAX) begin
			term = qcpm_pkg::TERM_MAX;
		end else if (quot < qcpm_pkg::TERM_MIN) begin
			term = qcpm_pkg::TERM_MIN;
		end else begin
			term = quot[qcpm_pkg::TERM_W-1:0];
		end
	end

endmodule

>>> rtl/qcpm_mixer.sv
// Four-motor mixer with output clamp and the registered output stage.
module qcpm_mixer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic [qcpm_pkg::THR_W-1:0]            thr,
	input  logic signed [qcpm_pkg::TERM_W-1:0]    px,
	input  logic signed [qcpm_pkg::TERM_W-1:0]    py,
	input  logic signed [qcpm_pkg::TERM_W-1:0]    pyaw,
	output logic                                  ready,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [qcpm_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	logic signed [qcpm_pkg::MIX_W-1:0] t_e, px_e, py_e, pyaw_e;
	logic signed [qcpm_pkg::MIX_W-1:0] sum_fa, sum_fb, sum_ra, sum_rb;
	logic [qcpm_pkg::MOTOR_W-1:0]      front_a_q, front_b_q, rear_a_q, rear_b_q;
	logic                              valid_q;

	function automatic logic [qcpm_pkg::MOTOR_W-1:0] clamp_motor(
		input logic signed [qcpm_pkg::MIX_W-1:0] v);
		logic [qcpm_pkg::MOTOR_W-1:0] r;
		if (v >= qcpm_pkg::PWM_MAX_S) begin
			r = qcpm_pkg::MOTOR_MAX;
		end else if (v <= qcpm_pkg::PWM_MIN_S) begin
			r = qcpm_pkg::MOTOR_FLOOR;
		end else begin
			r = v[qcpm_pkg::MOTOR_W-1:0];
		end
		return r;
	endfunction

	assign t_e    = signed'({{(qcpm_pkg::MIX_W-qcpm_pkg::THR_W){1'b0}}, thr});
	assign px_e   = qcpm_pkg::MIX_W'(px);
	assign py_e   = qcpm_pkg::MIX_W'(py);
	assign pyaw_e = qcpm_pkg::MIX_W'(pyaw);

	assign sum_fa = t_e + px_e - py_e + pyaw_e;
	assign sum_fb = t_e + px_e + py_e - pyaw_e;
	assign sum_ra = t_e - px_e + py_e + pyaw_e;
	assign sum_rb = t_e - px_e - py_e - pyaw_e;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_a_q <= clamp_motor(sum_fa);
			front_b_q <= clamp_motor(sum_fb);
			rear_a_q  <= clamp_motor(sum_ra);
			rear_b_q  <= clamp_motor(sum_rb);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0000, rear_b_q, rear_a_q, front_b_q, front_a_q};

endmodule

>>> rtl/quadrotor_cascade_pid_mixer_top.sv
// Top level of the quadrotor cascade PID controller and four-motor mixer.
//
// One input beat on the s_ channel carries a control tick: three angles, two gyro
// rates, the throttle, two sticks and the arm flag (in s_tuser). One output beat on
// the m_ channel carries the four clamped motor pulses for that tick. The gains are
// written through cfg_we / cfg_addr / cfg_data while the block is idle; only the user ensures this.
//
// Each tick is worked through a 13-step sequencer around one shared 13x21-bit
// multiplier and 36-bit accumulator: errors, integral update, then eight products
// (three per rate axis, two for heading), then the mix. s_tready rises again in the
// same cycle as the result beat becomes valid, so the next beat is accepted only
// after the previous tick has left the mix step.
// If the receiver holds m_tready low, the finished beat stays in the output
// register, the next tick is still accepted and computed, and the sequencer waits
// at the mix step until the output register is free.
// Reset restores the default gains, clears the integrals, error history and
// captured heading, and leaves the output channel empty.
module quadrotor_cascade_pid_mixer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// pitch_angle[15:0], roll_angle[31:16], heading_angle[47:32], rate_x[59:48],
	// rate_y[71:60], throttle[84:72], stick_pitch[92:85], stick_roll[100:93]
	input  logic [qcpm_pkg::IN_TDATA_W-1:0]      s_tdata,
	// armed[0]
	input  logic [qcpm_pkg::IN_TUSER_W-1:0]      s_tuser,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// motor_front_a[12:0], motor_front_b[25:13], motor_rear_a[38:26], motor_rear_b[51:39]
	output logic [qcpm_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_we,
	input  logic [qcpm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [qcpm_pkg::GAIN_W-1:0]          cfg_data
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_ERR   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_PREP  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_KP_Y  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_KD_Y  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_KI_Y  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_KP_X  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_KD_X  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_KI_X  = 4'd7;
	localparam logic [STEP_W-1:0] STEP_KP_H  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_KD_H  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_ACC_H = 4'd10;
	localparam logic [STEP_W-1:0] STEP_FIN_H = 4'd11;
	localparam logic [STEP_W-1:0] STEP_MIX   = 4'd12;

	logic              state_q;
	logic [STEP_W-1:0] step_q;

	// Captured tick.
	logic signed [qcpm_pkg::ANG_W-1:0]  pitch_q, roll_q, head_q;
	logic signed [qcpm_pkg::RATE_W-1:0] rx_q, ry_q;
	logic [qcpm_pkg::THR_W-1:0]         thr_q;
	logic [qcpm_pkg::STICK_W-1:0]       sp_q, sr_q;
	logic                               armed_q;

	// Gains.
	logic [qcpm_pkg::GAIN_W-1:0] kp_x_q, ki_x_q, kd_x_q;
	logic [qcpm_pkg::GAIN_W-1:0] kp_y_q, ki_y_q, kd_y_q;
	logic [qcpm_pkg::GAIN_W-1:0] kp_h_q, kd_h_q;

	// Loop state and per-tick working values.
	logic signed [qcpm_pkg::ERR_W-1:0]   e_x_q, e_y_q, last_x_q, last_y_q;
	logic signed [qcpm_pkg::HERR_W-1:0]  e_h_q, last_h_q;
	logic signed [qcpm_pkg::DIFF_W-1:0]  d_x_q, d_y_q;
	logic signed [qcpm_pkg::HDIFF_W-1:0] d_h_q;
	logic signed [qcpm_pkg::INTEG_W-1:0] integ_x_q, integ_y_q;
	logic signed [qcpm_pkg::ANG_W-1:0]   target_q;
	logic signed [qcpm_pkg::TERM_W-1:0]  px_q, py_q, pyaw_q;
	logic                                use_x_q, use_y_q;

	logic signed [qcpm_pkg::ERR_W-1:0]   sp_e, sr_e, pitch_e, roll_e, rx_e, ry_e;
	logic signed [qcpm_pkg::ERR_W-1:0]   e_x_n, e_y_n;
	logic signed [qcpm_pkg::HERR_W-1:0]  e_h_n;

	qcpm_pkg::mac_ctrl_t                 mac_ctrl;
	logic [qcpm_pkg::GAIN_W-1:0]         mac_gain;
	logic signed [qcpm_pkg::OPND_W-1:0]  mac_opnd;
	logic signed [qcpm_pkg::TERM_W-1:0]  mac_term;

	logic                                mix_ready, mix_load, idle_tick;
	logic [qcpm_pkg::THR_W-1:0]          mix_thr;
	logic signed [qcpm_pkg::TERM_W-1:0]  mix_px, mix_py, mix_pyaw;

	logic s_beat;

	// Integral with separation: added to only when the error is inside the band,
	// then held within the integral limit.
	function automatic logic signed [qcpm_pkg::INTEG_W-1:0] integ_next(
		input logic signed [qcpm_pkg::INTEG_W-1:0] integ,
		input logic signed [qcpm_pkg::ERR_W-1:0]   err,
		input logic                                use_i);
		logic signed [qcpm_pkg::ISUM_W-1:0]  sum;
		logic signed [qcpm_pkg::INTEG_W-1:0] r;
		sum = qcpm_pkg::ISUM_W'(integ) + qcpm_pkg::ISUM_W'(err >>> 2);
		if (!use_i) begin
			r = integ;
		end else if (sum > qcpm_pkg::INT_LIMIT) begin
			r = qcpm_pkg::INT_LIMIT[qcpm_pkg::INTEG_W-1:0];
		end else if (sum < qcpm_pkg::INT_NEG) begin
			r = qcpm_pkg::INT_NEG[qcpm_pkg::INTEG_W-1:0];
		end else begin
			r = sum[qcpm_pkg::INTEG_W-1:0];
		end
		return r;
	endfunction

	function automatic logic in_band(input logic signed [qcpm_pkg::ERR_W-1:0] err);
		return !(err >= qcpm_pkg::SEP_LIMIT || err <= qcpm_pkg::SEP_NEG);
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign s_beat   = s_tvalid && s_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_x_q <= 12'd480;
			ki_x_q <= 12'd8;
			kd_x_q <= 12'd480;
			kp_y_q <= 12'd400;
			ki_y_q <= 12'd8;
			kd_y_q <= 12'd352;
			kp_h_q <= 12'd640;
			kd_h_q <= 12'd960;
		end else if (cfg_we) begin
			case (cfg_addr)
				qcpm_pkg::REG_RATE_KP_X:  kp_x_q <= cfg_data;
				qcpm_pkg::REG_RATE_KI_X:  ki_x_q <= cfg_data;
				qcpm_pkg::REG_RATE_KD_X:  kd_x_q <= cfg_data;
				qcpm_pkg::REG_RATE_KP_Y:  kp_y_q <= cfg_data;
				qcpm_pkg::REG_RATE_KI_Y:  ki_y_q <= cfg_data;
				qcpm_pkg::REG_RATE_KD_Y:  kd_y_q <= cfg_data;
				qcpm_pkg::REG_HEADING_KP: kp_h_q <= cfg_data;
				qcpm_pkg::REG_HEADING_KD: kd_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (s_beat) begin
			pitch_q <= s_tdata[15:0];
			roll_q  <= s_tdata[31:16];
			head_q  <= s_tdata[47:32];
			rx_q    <= s_tdata[59:48];
			ry_q    <= s_tdata[71:60];
			thr_q   <= s_tdata[84:72];
			sp_q    <= s_tdata[92:85];
			sr_q    <= s_tdata[100:93];
			armed_q <= s_tuser[0];
		end
	end

	// Rate errors: the outer P loop (gain 2 on X, 1 on Y) gives the rate setpoint,
	// from which the measured rate is taken. Values stay within the error width.
	assign sp_e    = signed'({{(qcpm_pkg::ERR_W-qcpm_pkg::STICK_W){1'b0}}, sp_q});
	assign sr_e    = signed'({{(qcpm_pkg::ERR_W-qcpm_pkg::STICK_W){1'b0}}, sr_q});
	assign pitch_e = qcpm_pkg::ERR_W'(pitch_q);
	assign roll_e  = qcpm_pkg::ERR_W'(roll_q);
	assign rx_e    = qcpm_pkg::ERR_W'(rx_q);
	assign ry_e    = qcpm_pkg::ERR_W'(ry_q);

	assign e_y_n = ((qcpm_pkg::STICK_MID - sp_e) <<< qcpm_pkg::STICK_SHIFT) - pitch_e
		- (ry_e <<< qcpm_pkg::RATE_SHIFT);
	assign e_x_n = ((((sr_e - qcpm_pkg::STICK_MID) <<< qcpm_pkg::STICK_SHIFT) - roll_e) <<< 1)
		- (rx_e <<< qcpm_pkg::RATE_SHIFT);
	assign e_h_n = qcpm_pkg::HERR_W'(target_q) - qcpm_pkg::HERR_W'(head_q);

	// Operand selection for the shared multiplier. The integral product is
	// zeroed through its gain when the error is outside the separation band.
	always_comb begin
		mac_gain = '0;
		mac_opnd = '0;
		case (step_q)
			STEP_KP_Y: begin
				mac_gain = kp_y_q;
				mac_opnd = qcpm_pkg::OPND_W'(e_y_q);
			end
			STEP_KD_Y: begin
				mac_gain = kd_y_q;
				mac_opnd = qcpm_pkg::OPND_W'(d_y_q);
			end
			STEP_KI_Y: begin
				mac_gain = use_y_q ? ki_y_q : '0;
				mac_opnd = qcpm_pkg::OPND_W'(integ_y_q) <<< 2;
			end
			STEP_KP_X: begin
				mac_gain = kp_x_q;
				mac_opnd = qcpm_pkg::OPND_W'(e_x_q);
			end
			STEP_KD_X: begin
				mac_gain = kd_x_q;
				mac_opnd = qcpm_pkg::OPND_W'(d_x_q);
			end
			STEP_KI_X: begin
				mac_gain = use_x_q ? ki_x_q : '0;
				mac_opnd = qcpm_pkg::OPND_W'(integ_x_q) <<< 2;
			end
			STEP_KP_H: begin
				mac_gain = kp_h_q;
				mac_opnd = qcpm_pkg::OPND_W'(e_h_q);
			end
			STEP_KD_H: begin
				mac_gain = kd_h_q;
				mac_opnd = qcpm_pkg::OPND_W'(d_h_q);
			end
			default: begin
			end
		endcase
	end

	// The accumulator trails the multiplier through the product register; the first
	// product of a term loads it, which also lets the finished previous term be taken.
	always_comb begin
		mac_ctrl = '0;
		case (step_q)
			STEP_KD_Y, STEP_KD_X, STEP_KD_H: mac_ctrl.acc_load = (state_q == ST_RUN);
			STEP_KI_Y, STEP_KP_X, STEP_KI_X, STEP_KP_H, STEP_ACC_H:
				mac_ctrl.acc_add = (state_q == ST_RUN);
			default: begin
			end
		endcase
	end

	qcpm_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.gain (mac_gain),
		.opnd (mac_opnd),
		.term (mac_term)
	);

	// A disarmed tick or one at idle throttle drops all terms.
	assign idle_tick = !armed_q || (thr_q <= qcpm_pkg::IDLE_THROTTLE);
	assign mix_thr   = armed_q ? thr_q : qcpm_pkg::THR_DISARMED;
	assign mix_px    = idle_tick ? '0 : px_q;
	assign mix_py    = idle_tick ? '0 : py_q;
	assign mix_pyaw  = idle_tick ? '0 : pyaw_q;
	assign mix_load  = (state_q == ST_RUN) && (step_q == STEP_MIX) && mix_ready;

	qcpm_mixer u_mixer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (mix_load),
		.thr      (mix_thr),
		.px       (mix_px),
		.py       (mix_py),
		.pyaw     (mix_pyaw),
		.ready    (mix_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_ERR;
		end else if (state_q == ST_IDLE) begin
			if (s_beat) begin
				state_q <= ST_RUN;
				step_q  <= STEP_ERR;
			end
		end else if (step_q == STEP_MIX) begin
			if (mix_ready) begin
				state_q <= ST_IDLE;
				step_q  <= STEP_ERR;
			end
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// Loop state: error history, integrals and captured heading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q  <= '0;
			last_y_q  <= '0;
			last_h_q  <= '0;
			integ_x_q <= '0;
			integ_y_q <= '0;
			target_q  <= '0;
		end else if (state_q == ST_RUN) begin
			if (step_q == STEP_PREP) begin
				last_x_q  <= e_x_q;
				last_y_q  <= e_y_q;
				last_h_q  <= e_h_q;
				integ_x_q <= integ_next(integ_x_q, e_x_q, in_band(e_x_q));
				integ_y_q <= integ_next(integ_y_q, e_y_q, in_band(e_y_q));
			end else if (mix_load && idle_tick) begin
				integ_x_q <= '0;
				integ_y_q <= '0;
				target_q  <= head_q;
			end
		end
	end

	// Per-tick working registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (step_q)
				STEP_ERR: begin
					e_x_q <= e_x_n;
					e_y_q <= e_y_n;
					e_h_q <= e_h_n;
				end
				STEP_PREP: begin
					d_x_q   <= qcpm_pkg::DIFF_W'(e_x_q) - qcpm_pkg::DIFF_W'(last_x_q);
					d_y_q   <= qcpm_pkg::DIFF_W'(e_y_q) - qcpm_pkg::DIFF_W'(last_y_q);
					d_h_q   <= qcpm_pkg::HDIFF_W'(e_h_q) - qcpm_pkg::HDIFF_W'(last_h_q);
					use_x_q <= in_band(e_x_q);
					use_y_q <= in_band(e_y_q);
				end
				STEP_KD_X:  py_q   <= mac_term;
				STEP_KD_H:  px_q   <= mac_term;
				STEP_FIN_H: pyaw_q <= mac_term;
				default: begin
				end
			endcase
		end
	end

	// An accepted beat always starts the sequence at the error step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> (state_q == ST_RUN && step_q == STEP_ERR))
		else $error("accepted beat did not start the sequencer");

	// The integrals never leave the clamp range.
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_x_q <= qcpm_pkg::INT_LIMIT && integ_x_q >= qcpm_pkg::INT_NEG &&
		 integ_y_q <= qcpm_pkg::INT_LIMIT && integ_y_q >= qcpm_pkg::INT_NEG))
		else $error("integral outside clamp range");

	// A new result only appears out of the mix step.
	a_result_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_RUN && $past(step_q) == STEP_MIX))
		else $error("result loaded outside the mix step");

	// An idle or disarmed tick leaves both integrals cleared.
	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_load && idle_tick) |=> (integ_x_q == '0 && integ_y_q == '0))
		else $error("integrals not cleared on idle tick");

endmodule

>>> tb/quadrotor_cascade_pid_mixer_top_tb.sv
// Self-checking testbench for the quadrotor cascade PID controller and motor mixer.
`timescale 1ns / 1ps

module quadrotor_cascade_pid_mixer_top_tb;
	import qcpm_pkg::*;

	// Limits of the control law, kept apart from the design's own package.
	localparam int STICK_CENTER   = 15;
	localparam int SEPARATION     = 19200;
	localparam int INTEG_CLAMP    = 32000;
	localparam int TERM_CLAMP     = 32767;
	localparam int PULSE_TOP      = 7150;
	localparam int PULSE_LOW      = 5;
	localparam int THROTTLE_IDLE  = 100;
	localparam int DEFAULT_GAIN[8] = '{480, 8, 480, 400, 8, 352, 640, 960};

	// One control tick as it travels on the input channel.
	typedef struct {
		logic signed [ANG_W-1:0]  pitch;
		logic signed [ANG_W-1:0]  roll;
		logic signed [ANG_W-1:0]  heading;
		logic signed [RATE_W-1:0] rate_x;
		logic signed [RATE_W-1:0] rate_y;
		logic [THR_W-1:0]         throttle;
		logic [STICK_W-1:0]       stick_pitch;
		logic [STICK_W-1:0]       stick_roll;
		logic                     armed;
	} tick_t;

	// The four motor pulses of one output beat.
	typedef struct {
		logic [MOTOR_W-1:0] front_a;
		logic [MOTOR_W-1:0] front_b;
		logic [MOTOR_W-1:0] rear_a;
		logic [MOTOR_W-1:0] rear_b;
	} motors_t;

	typedef enum {GAINS_MAX, GAINS_ZERO, GAINS_DEFAULT, GAINS_RANDOM, GAINS_LOW} gain_plan_e;

	// Mirrors the controller state and gains, predicts the motor pulses of every
	// accepted tick and checks each output beat against the oldest prediction.
	class mixer_checker;
		int      gain[8];
		int      integ_x, integ_y;
		int      last_err_x, last_err_y, last_err_h;
		int      heading_hold;
		motors_t expected_motors[$];
		int      errors;
		int      beats_checked;

		function new();
			foreach (gain[i]) gain[i] = DEFAULT_GAIN[i];
			integ_x = 0;
			integ_y = 0;
			last_err_x = 0;
			last_err_y = 0;
			last_err_h = 0;
			heading_hold = 0;
			errors = 0;
			beats_checked = 0;
		endfunction

		function void set_gain(logic [CFG_ADDR_W-1:0] idx, int value);
			gain[idx] = value;
		endfunction

		function int pending();
			return expected_motors.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 50) $display("ERROR: %s", msg);
		endtask

		function int saturate_term(longint acc);
			longint q;
			q = acc / 2048;  // truncates toward zero
			if (q > TERM_CLAMP) q = TERM_CLAMP;
			if (q < -TERM_CLAMP) q = -TERM_CLAMP;
			return int'(q);
		endfunction

		function logic [MOTOR_W-1:0] clamp_pulse(longint v);
			if (v >= PULSE_TOP) return MOTOR_W'(PULSE_TOP);
			if (v <= PULSE_LOW) return MOTOR_W'(1);
			return MOTOR_W'(v);
		endfunction

		// Inner rate loop with integral separation and a clamped integral.
		function int rate_loop(input int err, inout int integ, inout int last_err,
				input int kp, input int ki, input int kd);
			bit     use_i;
			longint acc;
			use_i = (err < SEPARATION) && (err > -SEPARATION);
			if (use_i) integ += err >>> 2;  // floor of err / 4
			if (integ > INTEG_CLAMP) integ = INTEG_CLAMP;
			if (integ < -INTEG_CLAMP) integ = -INTEG_CLAMP;
			acc = longint'(kp) * err + longint'(kd) * (longint'(err) - last_err);
			if (use_i) acc += longint'(ki) * (longint'(integ) * 4);
			last_err = err;
			return saturate_term(acc);
		endfunction

		function motors_t mix_motors(tick_t t);
			int      set_x, set_y, err_x, err_y, err_h;
			int      term_x, term_y, term_yaw, thr;
			motors_t m;
			set_y = -(int'(t.stick_pitch) - STICK_CENTER) * 128 - int'(t.pitch);
			set_x = 2 * ((int'(t.stick_roll) - STICK_CENTER) * 128 - int'(t.roll));
			err_y = set_y - int'(t.rate_y) * 128;
			err_x = set_x - int'(t.rate_x) * 128;
			term_y = rate_loop(err_y, integ_y, last_err_y, gain[REG_RATE_KP_Y],
				gain[REG_RATE_KI_Y], gain[REG_RATE_KD_Y]);
			term_x = rate_loop(err_x, integ_x, last_err_x, gain[REG_RATE_KP_X],
				gain[REG_RATE_KI_X], gain[REG_RATE_KD_X]);
			err_h = heading_hold - int'(t.heading);
			term_yaw = saturate_term(longint'(gain[REG_HEADING_KP]) * err_h +
				longint'(gain[REG_HEADING_KD]) * (longint'(err_h) - last_err_h));
			last_err_h = err_h;
			thr = int'(t.throttle);
			// Disarmed or idling: clear the loops and recapture the heading.
			if (!t.armed || thr <= THROTTLE_IDLE) begin
				heading_hold = int'(t.heading);
				term_x = 0;
				term_y = 0;
				term_yaw = 0;
				integ_x = 0;
				integ_y = 0;
				if (!t.armed) thr = 1;
			end
			m.front_a = clamp_pulse(longint'(thr) + term_x - term_y + term_yaw);
			m.front_b = clamp_pulse(longint'(thr) + term_x + term_y - term_yaw);
			m.rear_a  = clamp_pulse(longint'(thr) - term_x + term_y + term_yaw);
			m.rear_b  = clamp_pulse(longint'(thr) - term_x - term_y - term_yaw);
			return m;
		endfunction

		function void note_tick(tick_t t);
			expected_motors.push_back(mix_motors(t));
		endfunction

		task check_motors(logic [OUT_TDATA_W-1:0] d);
			motors_t want;
			motors_t got;
			got.front_a = d[12:0];
			got.front_b = d[25:13];
			got.rear_a  = d[38:26];
			got.rear_b  = d[51:39];
			if (expected_motors.size() == 0) begin
				report($sformatf("output beat with no tick outstanding, data %h", d));
			end else begin
				want = expected_motors.pop_front();
				if (got.front_a != want.front_a)
					report($sformatf("beat %0d motor_front_a got %0d expected %0d",
						beats_checked, got.front_a, want.front_a));
				if (got.front_b != want.front_b)
					report($sformatf("beat %0d motor_front_b got %0d expected %0d",
						beats_checked, got.front_b, want.front_b));
				if (got.rear_a != want.rear_a)
					report($sformatf("beat %0d motor_rear_a got %0d expected %0d",
						beats_checked, got.rear_a, want.rear_a));
				if (got.rear_b != want.rear_b)
					report($sformatf("beat %0d motor_rear_b got %0d expected %0d",
						beats_checked, got.rear_b, want.rear_b));
			end
			beats_checked++;
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic [IN_TUSER_W-1:0]   s_tuser = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [GAIN_W-1:0]       cfg_data = '0;

	// Idling odds in percent per cycle, and a requested receiver hold-off in cycles.
	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int hold_request = 0;

	mixer_checker sb = new();

	quadrotor_cascade_pid_mixer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The run has a hard ceiling far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Receiver: checks every accepted output beat, then picks the next ready.
	// A requested hold-off is counted down here, one cycle per clock.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_motors(m_tdata);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= ready_stall_pct);
			end
		end
	end

	function automatic tick_t make_tick(int pitch, int roll, int heading, int rx, int ry,
			int thr, int sp, int sr, bit armed);
		tick_t t;
		t.pitch = ANG_W'(pitch);
		t.roll = ANG_W'(roll);
		t.heading = ANG_W'(heading);
		t.rate_x = RATE_W'(rx);
		t.rate_y = RATE_W'(ry);
		t.throttle = THR_W'(thr);
		t.stick_pitch = STICK_W'(sp);
		t.stick_roll = STICK_W'(sr);
		t.armed = armed;
		return t;
	endfunction

	// Mostly armed flight with moderate errors so the integrators stay engaged,
	// salted with full-range fields, idle throttle and disarmed ticks.
	function automatic tick_t random_tick();
		int pitch, roll, heading, rx, ry, thr, sp, sr;
		bit armed;
		if ($urandom_range(9) == 0) begin
			pitch = $urandom();
			roll = $urandom();
		end else begin
			pitch = int'($urandom_range(6000)) - 3000;
			roll = int'($urandom_range(5000)) - 2500;
		end
		if ($urandom_range(9) == 0) heading = $urandom();
		else heading = int'($urandom_range(4000)) - 2000;
		if ($urandom_range(9) == 0) begin
			rx = $urandom();
			ry = $urandom();
		end else begin
			rx = int'($urandom_range(80)) - 40;
			ry = int'($urandom_range(80)) - 40;
		end
		case ($urandom_range(19))
			0:       thr = $urandom_range(THROTTLE_IDLE);
			1:       thr = $urandom_range(8191);
			2:       thr = $urandom_range(8191, 6800);
			default: thr = $urandom_range(6000, THROTTLE_IDLE + 1);
		endcase
		if ($urandom_range(7) == 0) begin
			sp = $urandom_range(255);
			sr = $urandom_range(255);
		end else begin
			sp = STICK_CENTER - 8 + int'($urandom_range(16));
			sr = STICK_CENTER - 8 + int'($urandom_range(16));
		end
		armed = ($urandom_range(99) < 90);
		return make_tick(pitch, roll, heading, rx, ry, thr, sp, sr, armed);
	endfunction

	// Offers one tick, with random idle cycles ahead of it, and returns at the
	// edge that accepts it. The caller lowers s_tvalid after the last tick.
	task send_tick(tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, t.stick_roll, t.stick_pitch, t.throttle, t.rate_y, t.rate_x,
			t.heading, t.roll, t.pitch};
		s_tuser <= t.armed;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_tick(t);
	endtask

	// Waits until every predicted beat has arrived, then lets the sequencer settle.
	task wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Writes all eight gains on consecutive cycles; the block must be idle.
	task program_gains(gain_plan_e plan);
		int value;
		for (int i = 0; i < 8; i++) begin
			case (plan)
				GAINS_MAX:     value = 4095;
				GAINS_ZERO:    value = 0;
				GAINS_DEFAULT: value = DEFAULT_GAIN[i];
				GAINS_LOW:     value = $urandom_range(63);
				default:       value = $urandom_range(4095);
			endcase
			cfg_we <= 1'b1;
			cfg_addr <= CFG_ADDR_W'(i);
			cfg_data <= GAIN_W'(value);
			@(posedge clk);
			sb.set_gain(CFG_ADDR_W'(i), value);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		gain_plan_e plans[8];
		plans = '{GAINS_MAX, GAINS_ZERO, GAINS_RANDOM, GAINS_DEFAULT,
			GAINS_LOW, GAINS_RANDOM, GAINS_RANDOM, GAINS_RANDOM};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed ticks with the reset gains and no idling.
		// Disarmed: terms cleared, throttle forced low, heading captured.
		send_tick(make_tick(0, 0, 0, 0, 0, 0, 15, 15, 0));
		send_tick(make_tick(32767, -32768, 23040, 2047, -2048, 8191, 255, 0, 0));
		// Idle throttle boundary: cleared at 100, live at 101.
		send_tick(make_tick(0, 0, 0, 0, 0, 100, 15, 15, 1));
		send_tick(make_tick(300, -200, 0, 3, -3, 101, 15, 15, 1));
		// Mixer clamps at the top and at the floor.
		send_tick(make_tick(0, 0, 0, 0, 0, 8191, 15, 15, 1));
		send_tick(make_tick(0, 0, 0, 0, 0, 5, 15, 15, 1));
		send_tick(make_tick(0, 0, 0, 0, 0, 6, 15, 15, 1));
		// Integral separation right at the threshold, then just inside it.
		send_tick(make_tick(-19200, -9600, 0, 0, 0, 4000, 15, 15, 1));
		send_tick(make_tick(19200, 9600, 0, 0, 0, 4000, 15, 15, 1));
		send_tick(make_tick(-19199, -9599, 0, 0, 0, 4000, 15, 15, 1));
		send_tick(make_tick(19199, 9599, 0, 0, 0, 4000, 15, 15, 1));
		// A run of large errors inside the band drives the integral into its clamp.
		for (int i = 0; i < 8; i++)
			send_tick(make_tick(-19196, -9598, 0, 0, 0, 4000, 15, 15, 1));
		// Extreme angles, rates and sticks; the terms saturate.
		send_tick(make_tick(32767, 32767, -32768, -2048, 2047, 3000, 0, 255, 1));
		send_tick(make_tick(-32768, -32768, 32767, 2047, -2048, 3000, 255, 0, 1));
		send_tick(make_tick(-1, -1, -1, -1, -1, 8191, 255, 255, 1));
		// Heading held from the previous capture, yaw loop live.
		send_tick(make_tick(0, 0, 500, 0, 0, 200, 15, 15, 1));
		s_tvalid <= 1'b0;
		wait_drained();

		// Long receiver hold-off while ticks keep coming: the output register
		// fills, the next tick parks at the mix step and s_tready drops.
		hold_request = 300;
		for (int i = 0; i < 8; i++) send_tick(random_tick());
		s_tvalid <= 1'b0;
		wait_drained();

		// Random phases, each under its own gains and idling pattern.
		for (int p = 0; p < 8; p++) begin
			program_gains(plans[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_idle_pct = 47; ready_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  ready_stall_pct = 47; end
				default: begin send_idle_pct = 11; ready_stall_pct = 11; end
			endcase
			for (int i = 0; i < 228; i++) send_tick(random_tick());
			s_tvalid <= 1'b0;
			wait_drained();
		end

		send_idle_pct = 0;
		ready_stall_pct = 0;
		wait_drained();
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
